@@ src/rmq_pkg.sv @@
// shared types and constants for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int FIELD_W = 18;
	localparam int DIFF_W = FIELD_W + 1;
	localparam int DIV_QBITS = FIELD_W - 1;
	localparam int DIV_LAT = DIV_QBITS + 3;
	localparam logic signed [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;
endpackage

@@ src/rmq_if.sv @@
// matrix and quaternion channel interfaces, valid/ready handshake
// depends on rmq_pkg
interface rmq_mat_if;
	logic valid;
	logic ready;
	rmq_pkg::field_t entry_00, entry_01, entry_02;
	rmq_pkg::field_t entry_10, entry_11, entry_12;
	rmq_pkg::field_t entry_20, entry_21, entry_22;
	modport source(output valid, entry_00, entry_01, entry_02, entry_10, entry_11,
		entry_12, entry_20, entry_21, entry_22, input ready);
	modport sink(input valid, entry_00, entry_01, entry_02, entry_10, entry_11,
		entry_12, entry_20, entry_21, entry_22, output ready);
endinterface

interface rmq_quat_if;
	logic valid;
	logic ready;
	rmq_pkg::field_t quat_x, quat_y, quat_z, quat_w;
	logic [1:0] branch_taken;
	logic radicand_bad;
	modport source(output valid, quat_x, quat_y, quat_z, quat_w, branch_taken,
		radicand_bad, input ready);
	modport sink(input valid, quat_x, quat_y, quat_z, quat_w, branch_taken,
		radicand_bad, output ready);
endinterface

@@ src/rotation_matrix_to_quaternion.sv @@
// rotation matrix to unit quaternion, trace method with largest-diagonal fallback
// depends on rmq_pkg, rmq_if, rmq_div
// RTW = root bits, 18 at FRAC_BITS = 16; throughput: one transaction per cycle
// unless the output stalls, set by the one-bit-per-stage square root and restoring
// divider pipelines; all stages advance together when output is taken or empty
// reset: arst_n clears all valid bits; payload registers are not reset
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rmq_mat_if.sink mat,
	rmq_quat_if.source quat
);
	import rmq_pkg::*;

	localparam int RW = ((FRAC_BITS > FIELD_W) ? FRAC_BITS : FIELD_W) + 3;
	localparam int NW = RW - 1 + FRAC_BITS;
	localparam int RTW = (NW + 1) / 2;
	localparam int AW = NW + 2;

	logic en;
	logic signed [RW-1:0] e00, e11, e22, trace, rad, one;
	diff_t d_c [0:2];
	branch_t br_c;

	logic sq_v_s [0:RTW];
	branch_t sq_br_s [0:RTW];
	logic sq_bad_s [0:RTW];
	diff_t sq_d_s [0:RTW][0:2];
	logic [NW-1:0] sq_rem_s [0:RTW];
	logic [RTW-1:0] sq_res_s [0:RTW];

	logic dv_v_s [1:DIV_LAT];
	branch_t dv_br_s [1:DIV_LAT];
	logic dv_bad_s [1:DIV_LAT];
	field_t dv_main_s [1:DIV_LAT];
	field_t main_c;
	field_t dq [0:2];
	field_t qx, qy, qz, qw;

	assign en = !dv_v_s[DIV_LAT] || quat.ready;
	assign mat.ready = en;

	assign one = RW'(1) << FRAC_BITS;
	assign e00 = RW'(mat.entry_00);
	assign e11 = RW'(mat.entry_11);
	assign e22 = RW'(mat.entry_22);
	assign trace = e00 + e11 + e22;

	always_comb begin
		if (trace > 0) begin
			br_c = BR_TRACE;
			rad = trace + one;
			d_c[0] = DIFF_W'(mat.entry_12) - DIFF_W'(mat.entry_21);
			d_c[1] = DIFF_W'(mat.entry_20) - DIFF_W'(mat.entry_02);
			d_c[2] = DIFF_W'(mat.entry_01) - DIFF_W'(mat.entry_10);
		end else if (e00 >= e11 && e00 >= e22) begin
			br_c = BR_X;
			rad = one + e00 - e11 - e22;
			d_c[0] = DIFF_W'(mat.entry_01) + DIFF_W'(mat.entry_10);
			d_c[1] = DIFF_W'(mat.entry_02) + DIFF_W'(mat.entry_20);
			d_c[2] = DIFF_W'(mat.entry_12) - DIFF_W'(mat.entry_21);
		end else if (e11 > e22) begin
			br_c = BR_Y;
			rad = one + e11 - e00 - e22;
			d_c[0] = DIFF_W'(mat.entry_10) + DIFF_W'(mat.entry_01);
			d_c[1] = DIFF_W'(mat.entry_21) + DIFF_W'(mat.entry_12);
			d_c[2] = DIFF_W'(mat.entry_20) - DIFF_W'(mat.entry_02);
		end else begin
			br_c = BR_Z;
			rad = one + e22 - e00 - e11;
			d_c[0] = DIFF_W'(mat.entry_20) + DIFF_W'(mat.entry_02);
			d_c[1] = DIFF_W'(mat.entry_21) + DIFF_W'(mat.entry_12);
			d_c[2] = DIFF_W'(mat.entry_01) - DIFF_W'(mat.entry_10);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= RTW; k++) sq_v_s[k] <= 1'b0;
			for (int k = 1; k <= DIV_LAT; k++) dv_v_s[k] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= mat.valid;
			for (int k = 1; k <= RTW; k++) sq_v_s[k] <= sq_v_s[k-1];
			dv_v_s[1] <= sq_v_s[RTW];
			for (int k = 2; k <= DIV_LAT; k++) dv_v_s[k] <= dv_v_s[k-1];
		end
	end

	// square root, one result bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			sq_br_s[0] <= br_c;
			sq_bad_s[0] <= rad <= 0;
			sq_d_s[0] <= d_c;
			sq_rem_s[0] <= (rad <= 0) ? '0 : (NW'(rad[RW-2:0]) << FRAC_BITS);
			sq_res_s[0] <= '0;
			for (int k = 1; k <= RTW; k++) begin
				sq_br_s[k] <= sq_br_s[k-1];
				sq_bad_s[k] <= sq_bad_s[k-1];
				sq_d_s[k] <= sq_d_s[k-1];
				if (AW'(sq_rem_s[k-1]) >= ((AW'(sq_res_s[k-1]) << (RTW - k + 1))
						| (AW'(1) << (2 * (RTW - k))))) begin
					sq_rem_s[k] <= NW'(AW'(sq_rem_s[k-1])
						- ((AW'(sq_res_s[k-1]) << (RTW - k + 1))
						| (AW'(1) << (2 * (RTW - k)))));
					sq_res_s[k] <= sq_res_s[k-1] | (RTW'(1) << (RTW - k));
				end else begin
					sq_rem_s[k] <= sq_rem_s[k-1];
					sq_res_s[k] <= sq_res_s[k-1];
				end
			end
		end
	end

	assign main_c = ((sq_res_s[RTW] >> 1) > RTW'(SAT_MAX)) ? SAT_MAX
		: field_t'(sq_res_s[RTW] >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_br_s[1] <= sq_br_s[RTW];
			dv_bad_s[1] <= sq_bad_s[RTW];
			dv_main_s[1] <= main_c;
			for (int k = 2; k <= DIV_LAT; k++) begin
				dv_br_s[k] <= dv_br_s[k-1];
				dv_bad_s[k] <= dv_bad_s[k-1];
				dv_main_s[k] <= dv_main_s[k-1];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		rmq_div #(.FRAC_BITS(FRAC_BITS), .RTW(RTW)) u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.d(sq_d_s[RTW][g]), .root(sq_res_s[RTW]), .q(dq[g])
		);
	end

	always_comb begin
		case (dv_br_s[DIV_LAT])
			BR_TRACE: begin qx = dq[0]; qy = dq[1]; qz = dq[2]; qw = dv_main_s[DIV_LAT]; end
			BR_X:     begin qx = dv_main_s[DIV_LAT]; qy = dq[0]; qz = dq[1]; qw = dq[2]; end
			BR_Y:     begin qx = dq[0]; qy = dv_main_s[DIV_LAT]; qz = dq[1]; qw = dq[2]; end
			BR_Z:     begin qx = dq[0]; qy = dq[1]; qz = dv_main_s[DIV_LAT]; qw = dq[2]; end
			default:  begin qx = '0; qy = '0; qz = '0; qw = '0; end
		endcase
	end

	assign quat.valid = dv_v_s[DIV_LAT];
	assign quat.branch_taken = dv_br_s[DIV_LAT];
	assign quat.radicand_bad = dv_bad_s[DIV_LAT];
	assign quat.quat_x = dv_bad_s[DIV_LAT] ? '0 : qx;
	assign quat.quat_y = dv_bad_s[DIV_LAT] ? '0 : qy;
	assign quat.quat_z = dv_bad_s[DIV_LAT] ? '0 : qz;
	assign quat.quat_w = dv_bad_s[DIV_LAT] ? '0 : qw;
endmodule

@@ src/rmq_div.sv @@
// pipelined rounded divider: d * 2^F / (2 * root), half away from zero, saturated
// depends on rmq_pkg; the pipeline advances only while en is high
module rmq_div #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int RTW = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  rmq_pkg::diff_t      d,
	input  logic [RTW-1:0]      root,
	output rmq_pkg::field_t     q
);
	import rmq_pkg::*;

	localparam int NUMW = DIFF_W + FRAC_BITS + 1;
	localparam int DENW = RTW + 1 + DIV_QBITS;
	localparam int CW = ((NUMW > DENW) ? NUMW : DENW) + 1;

	logic [DIFF_W-1:0] mag;
	logic [CW-1:0] num_s1, den_s1;
	logic neg_s1;
	logic [CW-1:0] rem_s [0:DIV_QBITS];
	logic [CW-1:0] den_s [0:DIV_QBITS];
	logic [DIV_QBITS-1:0] quo_s [0:DIV_QBITS];
	logic ovf_s [0:DIV_QBITS];
	logic neg_s [0:DIV_QBITS];
	field_t res_s;
	logic unused_rst;

	assign unused_rst = arst_n;
	assign mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= (CW'(mag) << FRAC_BITS) + CW'(root);
			den_s1 <= CW'(root) << 1;
			neg_s1 <= d[DIFF_W-1];
			rem_s[0] <= num_s1;
			den_s[0] <= den_s1;
			quo_s[0] <= '0;
			neg_s[0] <= neg_s1;
			// quotient too large for the field saturates
			ovf_s[0] <= num_s1 >= (den_s1 << DIV_QBITS);
			for (int k = 1; k <= DIV_QBITS; k++) begin
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
				if (rem_s[k-1] >= (den_s[k-1] << (DIV_QBITS - k))) begin
					rem_s[k] <= rem_s[k-1] - (den_s[k-1] << (DIV_QBITS - k));
					quo_s[k] <= quo_s[k-1] | (DIV_QBITS'(1) << (DIV_QBITS - k));
				end else begin
					rem_s[k] <= rem_s[k-1];
					quo_s[k] <= quo_s[k-1];
				end
			end
			if (ovf_s[DIV_QBITS])
				res_s <= neg_s[DIV_QBITS] ? ~SAT_MAX : SAT_MAX;
			else
				res_s <= neg_s[DIV_QBITS] ? -field_t'({1'b0, quo_s[DIV_QBITS]})
					: field_t'({1'b0, quo_s[DIV_QBITS]});
		end
	end

	assign q = res_s;
endmodule

@@ src/rmq_checker.sv @@
// port-level checks for the rotation matrix to quaternion block, bound to the top
// depends on rmq_pkg, rmq_if
module rmq_checker (
	input logic clk,
	input logic arst_n,
	rmq_mat_if.sink mat,
	rmq_quat_if.source quat
);
	import rmq_pkg::*;

	// held transaction stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.ready |=> quat.valid)
		else $error("output transaction dropped under stall");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.radicand_bad |-> quat.quat_x == 0 && quat.quat_y == 0
		&& quat.quat_z == 0 && quat.quat_w == 0)
		else $error("bad radicand with nonzero quaternion");

	// on the trace branch the root component w is never negative
	a_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.radicand_bad && quat.branch_taken == BR_TRACE
		|-> !quat.quat_w[FIELD_W-1])
		else $error("negative w on trace branch");

	// the valid bits clear while reset is asserted
	a_rst: assert property (@(posedge clk) !arst_n |=> !quat.valid)
		else $error("output valid during reset");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!quat.valid |-> mat.ready)
		else $error("input stalled with empty output");
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
	.clk(clk), .arst_n(arst_n), .mat(mat), .quat(quat)
);
